// ===== rtl/core/fwpi_pkg.sv =====
// Package for the four-wheel PI velocity controller.
// Holds the widths, register reset values, codes, the sequencer types and the rounding helper.
// Depends on nothing. All other files in rtl/core import it.
`timescale 1ns / 1ps

package fwpi_pkg;

  // Number of wheel slots in the stream payload. WHEEL_COUNT may use fewer.
  localparam int unsigned WheelSlots        = 4;
  localparam int unsigned WheelCountDefault = 4;

  // Field widths.
  localparam int unsigned VelW     = 16;  // Q7.8 setpoint, angle step, integral
  localparam int unsigned DutyW    = 15;
  localparam int unsigned InTdataW = 2 * WheelSlots * VelW;
  localparam int unsigned InTuserW = 2;
  localparam int unsigned OutTdataW = ((WheelSlots * DutyW + 7) / 8) * 8;

  // Datapath widths.
  localparam int unsigned ErrW   = 27;
  localparam int unsigned AccW   = 28;
  localparam int unsigned DriveW = 29;
  localparam int unsigned MulAW  = 29;
  localparam int unsigned MulBW  = 25;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned RndW   = ProdW - 15;

  localparam int signed DutyMax = 10000;

  // Configuration port.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    RegKp    = 3'd0,
    RegKi    = 3'd1,
    RegTick  = 3'd2,
    RegRate  = 3'd3,
    RegLimit = 3'd4,
    RegScale = 3'd5
  } reg_idx_e;

  localparam logic [15:0] KpReset    = 16'd1638;
  localparam logic [15:0] KiReset    = 16'd983;
  localparam logic [15:0] TickReset  = 16'd655;
  localparam logic [9:0]  RateReset  = 10'd100;
  localparam logic [14:0] LimitReset = 15'd2560;
  localparam logic [23:0] ScaleReset = 24'd85333;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [15:0] tick_seconds;
    logic [9:0]  tick_rate_hz;
    logic [14:0] integral_limit;
    logic [23:0] duty_scale;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Eight steps per wheel around the shared multiplier.
  typedef enum logic [2:0] {
    PH_PV,
    PH_ERR,
    PH_TS,
    PH_INT,
    PH_KI,
    PH_DRV,
    PH_DS,
    PH_DUTY
  } phase_e;

  // Divide by 2^16, rounding to nearest with ties toward plus infinity.
  function automatic logic signed [RndW-1:0] round_q16(input logic signed [ProdW-1:0] x);
    logic signed [ProdW:0] s;
    s = (ProdW+1)'(x) + (ProdW+1)'(32768);
    return s[ProdW:16];
  endfunction

endpackage

// ===== rtl/core/fwpi_cfg_regs.sv =====
// Configuration register file of the four-wheel PI velocity controller.
// APB-style write and read port; presents the register values as one struct.
// Depends on fwpi_pkg.
`timescale 1ns / 1ps

module fwpi_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fwpi_pkg::AddrW-1:0]  paddr,
  input  logic [fwpi_pkg::DataW-1:0]  pwdata,
  output logic [fwpi_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output fwpi_pkg::cfg_t              cfg_o
);
  import fwpi_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain        <= KpReset;
      cfg_q.ki_gain        <= KiReset;
      cfg_q.tick_seconds   <= TickReset;
      cfg_q.tick_rate_hz   <= RateReset;
      cfg_q.integral_limit <= LimitReset;
      cfg_q.duty_scale     <= ScaleReset;
    end else if (wr_en) begin
      unique case (idx)
        RegKp:    cfg_q.kp_gain        <= pwdata[15:0];
        RegKi:    cfg_q.ki_gain        <= pwdata[15:0];
        RegTick:  cfg_q.tick_seconds   <= pwdata[15:0];
        RegRate:  cfg_q.tick_rate_hz   <= pwdata[9:0];
        RegLimit: cfg_q.integral_limit <= pwdata[14:0];
        RegScale: cfg_q.duty_scale     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegKp:    prdata = {16'd0, cfg_q.kp_gain};
      RegKi:    prdata = {16'd0, cfg_q.ki_gain};
      RegTick:  prdata = {16'd0, cfg_q.tick_seconds};
      RegRate:  prdata = {22'd0, cfg_q.tick_rate_hz};
      RegLimit: prdata = {17'd0, cfg_q.integral_limit};
      RegScale: prdata = {8'd0, cfg_q.duty_scale};
      default:  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/four_wheel_pi_velocity_controller.sv =====
// Four-wheel PI velocity controller with feedforward and integral clamp (top level).
// The input beat starts ST_RUN, where each wheel walks its eight phases; ST_FINISH then loads the result
// register, which raises m_axis_tvalid. A new input beat is taken only back in ST_IDLE, after the tick ends;
// the sequence runs around the single shared multiplier, which every wheel visits five times in its eight steps.
// Reset: integrals, held setpoints, held angle steps and duties clear to zero; registers take defaults.
`timescale 1ns / 1ps

module four_wheel_pi_velocity_controller #(
  parameter int unsigned WHEEL_COUNT = fwpi_pkg::WheelCountDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, low bit up: setpoint_0..3, angle_step_0..3 (16 bits each)
  input  logic [fwpi_pkg::InTdataW-1:0]  s_axis_tdata,
  // tuser, low bit up: setpoint_valid, encoder_valid
  input  logic [fwpi_pkg::InTuserW-1:0]  s_axis_tuser,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, low bit up: duty_0..3 (15 bits each), then four zero bits
  output logic [fwpi_pkg::OutTdataW-1:0] m_axis_tdata,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fwpi_pkg::AddrW-1:0]     paddr,
  input  logic [fwpi_pkg::DataW-1:0]     pwdata,
  output logic [fwpi_pkg::DataW-1:0]     prdata,
  output logic                           pready
);
  import fwpi_pkg::*;

  localparam logic [1:0] LastWheel = 2'(WHEEL_COUNT - 1);

  cfg_t cfg;

  fwpi_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer state. One wheel at a time walks through the eight phases.
  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] wheel_q, wheel_d;

  // Per-wheel state and per-wheel results of the current tick.
  logic signed [VelW-1:0]  held_sp_q   [WheelSlots];
  logic signed [VelW-1:0]  held_step_q [WheelSlots];
  logic signed [VelW-1:0]  integ_q     [WheelSlots];
  logic signed [DutyW-1:0] duty_q      [WheelSlots];

  // Datapath registers shared by all wheels.
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ErrW-1:0]   err_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [DriveW-1:0] drive_q;

  logic                     out_valid_q;
  logic [OutTdataW-1:0]     out_data_q;

  // Input handshake and control from the output decoder.
  logic in_beat, mul_en, load_out;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod_w;
  logic signed [RndW-1:0]   prod_rnd;

  logic signed [VelW-1:0]   cur_sp, cur_step, cur_integ;
  logic signed [DriveW-1:0] integ_sum, lim_pos, integ_new;
  logic signed [DutyW-1:0]  duty_new;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign cur_sp    = held_sp_q[wheel_q];
  assign cur_step  = held_step_q[wheel_q];
  assign cur_integ = integ_q[wheel_q];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    wheel_d = wheel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_RUN;
          phase_d = PH_PV;
          wheel_d = '0;
        end
      end
      ST_RUN: begin
        if (phase_q == PH_DUTY) begin
          phase_d = PH_PV;
          if (wheel_q == LastWheel) begin
            state_d = ST_FINISH;
          end else begin
            wheel_d = wheel_q + 2'd1;
          end
        end else begin
          phase_d = phase_e'(phase_q + 3'd1);
        end
      end
      ST_FINISH: begin
        // A finished tick waits here only while the previous result is still unread.
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output decoder: multiplier operands and the output register load.
  always_comb begin
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    load_out = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
    if (state_q == ST_RUN) begin
      unique case (phase_q)
        PH_PV: begin
          // Measured velocity: angle step times tick rate.
          mul_en = 1'b1;
          mul_a  = MulAW'(cur_step);
          mul_b  = MulBW'($signed({1'b0, cfg.tick_rate_hz}));
        end
        PH_TS: begin
          mul_en = 1'b1;
          mul_a  = MulAW'(err_q);
          mul_b  = MulBW'($signed({1'b0, cfg.tick_seconds}));
        end
        PH_INT: begin
          mul_en = 1'b1;
          mul_a  = MulAW'(err_q);
          mul_b  = MulBW'($signed({1'b0, cfg.kp_gain}));
        end
        PH_KI: begin
          mul_en = 1'b1;
          mul_a  = MulAW'(cur_integ);
          mul_b  = MulBW'($signed({1'b0, cfg.ki_gain}));
        end
        PH_DS: begin
          mul_en = 1'b1;
          mul_a  = drive_q;
          mul_b  = $signed({1'b0, cfg.duty_scale});
        end
        default: ;
      endcase
    end
  end

  // The one shared multiplier; its product is always registered before use.
  assign prod_w   = mul_a * mul_b;
  assign prod_rnd = round_q16(prod_q);

  // Integral update with symmetric anti-windup clamp.
  assign lim_pos   = $signed({{(DriveW - 15){1'b0}}, cfg.integral_limit});
  assign integ_sum = DriveW'(cur_integ) + DriveW'(prod_rnd);

  always_comb begin
    priority if (integ_sum > lim_pos) begin
      integ_new = lim_pos;
    end else if (integ_sum < -lim_pos) begin
      integ_new = -lim_pos;
    end else begin
      integ_new = integ_sum;
    end
  end

  // Duty saturation to plus or minus 100 percent.
  always_comb begin
    priority if (prod_rnd > RndW'(DutyMax)) begin
      duty_new = DutyW'(DutyMax);
    end else if (prod_rnd < -RndW'(DutyMax)) begin
      duty_new = -DutyW'(DutyMax);
    end else begin
      duty_new = DutyW'(prod_rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_PV;
      wheel_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      wheel_q <= wheel_d;
    end
  end

  // Per-wheel state. Wheels at or above WHEEL_COUNT are never touched and report zero duty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WheelSlots; w++) begin
        held_sp_q[w]   <= '0;
        held_step_q[w] <= '0;
        integ_q[w]     <= '0;
        duty_q[w]      <= '0;
      end
    end else begin
      if (in_beat) begin
        for (int w = 0; w < WheelSlots; w++) begin
          if (w < WHEEL_COUNT) begin
            if (s_axis_tuser[0]) begin
              held_sp_q[w] <= s_axis_tdata[w*VelW +: VelW];
            end
            if (s_axis_tuser[1]) begin
              held_step_q[w] <= s_axis_tdata[(WheelSlots + w)*VelW +: VelW];
            end
          end
        end
      end
      if (state_q == ST_RUN && phase_q == PH_INT) begin
        integ_q[wheel_q] <= VelW'(integ_new);
      end
      if (state_q == ST_RUN && phase_q == PH_DUTY) begin
        duty_q[wheel_q] <= duty_new;
      end
    end
  end

  // Shared datapath registers. Each phase that uses a product takes the one from the phase before it.
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_w;
    end
    if (state_q == ST_RUN) begin
      unique case (phase_q)
        PH_ERR:  err_q   <= ErrW'(cur_sp) - ErrW'(prod_q);
        PH_KI:   acc_q   <= AccW'(prod_rnd);
        PH_DRV:  drive_q <= DriveW'(cur_sp) + DriveW'(acc_q) + DriveW'(prod_rnd);
        default: ;
      endcase
    end
  end

  // Result register: holds a finished tick until the downstream side takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q[OutTdataW-1:WheelSlots*DutyW] <= '0;
      for (int w = 0; w < WheelSlots; w++) begin
        out_data_q[w*DutyW +: DutyW] <= duty_q[w];
      end
    end
  end

endmodule
